>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the handle table allocator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTA_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("handle table allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define HTA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("handle table allocator check failed");

`endif

>>> hdl/hta_pkg.sv
// ----------------------------------------------------------------------------
// hta_pkg
// Types, codes and sizes shared by the handle table allocator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hta_pkg;

	// Field widths of the request and response beats.
	localparam int HANDLE_BITS = 6;
	localparam int VALUE_BITS  = 32;
	localparam int KIND_BITS   = 2;
	localparam int STATUS_BITS = 2;

	// Default table depth; at most 2**HANDLE_BITS.
	localparam int MAX_HANDLES = 64;

	// Operation codes.
	localparam logic [KIND_BITS-1:0] KIND_ALLOC   = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_RELEASE = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_LOOKUP  = 2'd2;

	// Status codes.
	localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_INVALID = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_FULL    = 2'd2;

	typedef struct packed {
		logic [KIND_BITS-1:0]   kind;
		logic [HANDLE_BITS-1:0] handle_in;
		logic [VALUE_BITS-1:0]  value_in;
	} req_beat_t;

	typedef struct packed {
		logic [HANDLE_BITS-1:0] handle_out;
		logic [VALUE_BITS-1:0]  value_out;
		logic [STATUS_BITS-1:0] status;
	} rsp_beat_t;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic commit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic rsp_blocked;
	} dp_sts_t;

endpackage

>>> hdl/handle_table_allocator.sv
// ----------------------------------------------------------------------------
// Handle table allocator.
// Requests arrive on the req channel (req_valid, req_stall, req) and each gives
// exactly one response on the rsp channel (rsp_valid, rsp_stall, rsp); a beat
// moves at a rising edge where valid is high and stall is low. Kind allocate
// stores a value and grants a handle (the latest freed gap, else the next
// sequential one), release checks a handle, frees it and returns its value,
// lookup returns the stored value.
// A taken request is captured together with the registered read of the entry
// and gap memories; its commit does the write-back and loads the response
// beat. A new request is taken only after the previous one has committed.
// A request may be taken while the previous response still waits in the
// output register; if the receiver keeps stalling, the next request holds in
// its commit cycle and req_stall stays high until the register is free.
// Reset clears the valid bits and both counters at once; the entry and gap
// memories need no clearing pass, so requests are taken from the first cycle.
// MAX_HANDLES ranges from 2 to 64.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module handle_table_allocator #(
	parameter int MAX_HANDLES = hta_pkg::MAX_HANDLES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  hta_pkg::req_beat_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output hta_pkg::rsp_beat_t rsp
);

	hta_pkg::dp_cmd_t cmd;
	hta_pkg::dp_sts_t sts;

	// Sequencer.
	hta_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Storage and response path.
	hta_datapath #(
		.MAX_HANDLES (MAX_HANDLES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Checks.
	`HTA_ASSERT_SAME(a_capture_commit_apart, cmd.capture, !cmd.commit)
	`HTA_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall)
	`HTA_ASSERT_NEXT(a_commit_gives_beat, cmd.commit, rsp_valid)
	`HTA_ASSERT_SAME(a_full_handle_zero,
		rsp_valid && (rsp.status == hta_pkg::STATUS_FULL), rsp.handle_out == '0)

endmodule

>>> hdl/hta_ctrl.sv
// ----------------------------------------------------------------------------
// hta_ctrl
// Sequences one request at a time: capture with memory read, then commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hta_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  hta_pkg::dp_sts_t  sts,
	output hta_pkg::dp_cmd_t  cmd
);

	hta_pkg::ctrl_state_t state_q;
	hta_pkg::ctrl_state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hta_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state: a captured request commits as soon as the response register is free.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			hta_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_next = hta_pkg::ST_EXEC;
				end
			end
			hta_pkg::ST_EXEC: begin
				if (!sts.rsp_blocked) begin
					state_next = hta_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = hta_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs to the request channel and the datapath.
	always_comb begin
		req_stall   = 1'b1;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			hta_pkg::ST_IDLE: begin
				req_stall   = 1'b0;
				cmd.capture = req_valid;
			end
			hta_pkg::ST_EXEC: begin
				cmd.commit = !sts.rsp_blocked;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

endmodule

>>> hdl/hta_datapath.sv
// ----------------------------------------------------------------------------
// hta_datapath
// Entry and gap memories, valid bits, counters and the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hta_datapath #(
	parameter int MAX_HANDLES = hta_pkg::MAX_HANDLES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  hta_pkg::req_beat_t req,
	input  hta_pkg::dp_cmd_t   cmd,
	output hta_pkg::dp_sts_t   sts,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output hta_pkg::rsp_beat_t rsp
);

	localparam int HB  = hta_pkg::HANDLE_BITS;
	localparam int VB  = hta_pkg::VALUE_BITS;
	localparam int IW  = (MAX_HANDLES > 1) ? $clog2(MAX_HANDLES) : 1;
	localparam int CW  = $clog2(MAX_HANDLES + 1);
	localparam logic [HB:0]   MAX_EXT = (HB + 1)'(MAX_HANDLES);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_HANDLES);

	// Storage.
	logic [VB-1:0]    entry_mem [MAX_HANDLES];
	logic [IW-1:0]    gap_mem   [MAX_HANDLES];
	logic [MAX_HANDLES-1:0] valid_q;
	logic [CW-1:0]    gap_q;
	logic [CW-1:0]    live_q;

	// Captured request and registered memory reads.
	logic [hta_pkg::KIND_BITS-1:0] kind_s1;
	logic [HB-1:0]    handle_s1;
	logic [VB-1:0]    value_s1;
	logic [VB-1:0]    rd_value_s1;
	logic [IW-1:0]    rd_gap_s1;

	// Response register.
	logic             rsp_valid_q;
	hta_pkg::rsp_beat_t rsp_q;

	// Decode of the captured request.
	logic [CW-1:0]    gap_dec;
	logic [IW-1:0]    gap_rd_idx;
	logic [IW-1:0]    h_idx;
	logic             h_ok;
	logic             alloc_ok;
	logic             alloc_from_gap;
	logic [IW-1:0]    slot;
	logic             release_ok;
	logic             push_gap;
	logic [CW:0]      h_plus_one;
	logic [CW:0]      high_water;
	logic [CW-1:0]    live_dec;
	hta_pkg::rsp_beat_t rsp_next;

	assign gap_dec    = gap_q - CW'(1);
	assign gap_rd_idx = gap_dec[IW-1:0];

	// Memory reads happen on capture, so the data is ready for the commit cycle.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_s1     <= req.kind;
			handle_s1   <= req.handle_in;
			value_s1    <= req.value_in;
			rd_value_s1 <= entry_mem[req.handle_in[IW-1:0]];
			rd_gap_s1   <= gap_mem[gap_rd_idx];
		end
	end

	// Handle check and slot choice.
	assign h_idx = handle_s1[IW-1:0];
	assign h_ok  = ({1'b0, handle_s1} < MAX_EXT) && valid_q[h_idx];

	assign alloc_from_gap = (gap_q != '0);
	assign alloc_ok = (kind_s1 == hta_pkg::KIND_ALLOC) &&
		(alloc_from_gap || (live_q < MAX_CNT));
	assign slot = alloc_from_gap ? rd_gap_s1 : live_q[IW-1:0];

	assign release_ok = (kind_s1 == hta_pkg::KIND_RELEASE) && h_ok;

	// A released handle becomes a gap unless it sits at the top of the used range.
	assign h_plus_one = {1'b0, CW'(h_idx)} + (CW + 1)'(1);
	assign high_water = {1'b0, live_q} + {1'b0, gap_q};
	assign push_gap   = (h_plus_one < high_water) && (gap_q < MAX_CNT);
	assign live_dec   = live_q - CW'(1);

	// Response beat.
	always_comb begin
		rsp_next.handle_out = handle_s1;
		rsp_next.value_out  = '0;
		rsp_next.status     = hta_pkg::STATUS_OK;
		unique case (kind_s1)
			hta_pkg::KIND_ALLOC: begin
				if (alloc_ok) begin
					rsp_next.handle_out = HB'(slot);
				end else begin
					rsp_next.handle_out = '0;
					rsp_next.status     = hta_pkg::STATUS_FULL;
				end
			end
			hta_pkg::KIND_RELEASE, hta_pkg::KIND_LOOKUP: begin
				if (h_ok) begin
					rsp_next.value_out = rd_value_s1;
				end else begin
					rsp_next.status = hta_pkg::STATUS_INVALID;
				end
			end
			default: begin
				rsp_next.status = hta_pkg::STATUS_INVALID;
			end
		endcase
	end

	// Memory writes at commit.
	always_ff @(posedge clk) begin
		if (cmd.commit && alloc_ok) begin
			entry_mem[slot] <= value_s1;
		end
		if (cmd.commit && release_ok && push_gap) begin
			gap_mem[gap_q[IW-1:0]] <= h_idx;
		end
	end

	// Valid bits and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			gap_q   <= '0;
			live_q  <= '0;
		end else if (cmd.commit) begin
			if (alloc_ok) begin
				valid_q[slot] <= 1'b1;
				live_q        <= live_q + CW'(1);
				if (alloc_from_gap) begin
					gap_q <= gap_dec;
				end
			end else if (release_ok) begin
				valid_q[h_idx] <= 1'b0;
				live_q         <= live_dec;
				if (live_dec == '0) begin
					gap_q <= '0;
				end else if (push_gap) begin
					gap_q <= gap_q + CW'(1);
				end
			end
		end
	end

	// Response register: loads on commit, empties when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q <= rsp_next;
		end
	end

	assign sts.rsp_blocked = rsp_valid_q && rsp_stall;
	assign rsp_valid       = rsp_valid_q;
	assign rsp             = rsp_q;

endmodule
